// ===== sv/smi_pkg.sv =====
// Shared types, widths and cofactor index tables for the small matrix inverse.
package smi_pkg;

  localparam int DATA_WIDTH = 32;
  // Entries are Q(DATA_WIDTH/2).(DATA_WIDTH/2); the divider range check relies on it.
  localparam int FRAC_BITS  = DATA_WIDTH / 2;
  localparam int NLANE      = 9;
  localparam int IDX_W      = $clog2(NLANE);

  localparam int PROD_W = 2 * DATA_WIDTH;       // entry x entry
  localparam int COF_W  = PROD_W + 1;           // signed cofactor
  localparam int CMAG_W = PROD_W;               // cofactor magnitude
  localparam int TERM_W = DATA_WIDTH + COF_W;   // entry x cofactor
  localparam int DET_W  = TERM_W + 2;           // sum of three terms
  localparam int DMAG_W = DET_W - 1;            // determinant magnitude
  localparam int QBITS  = 2 * FRAC_BITS + 1;    // quotient bits incl. rounding bit
  localparam int MAG_W  = QBITS;                // rounded magnitude

  localparam int COF_ST = 2;
  localparam int DET_ST = 4;
  localparam int DIV_ST = QBITS + 2;
  localparam int OUT_ST = 1;
  localparam int NSTAGE = COF_ST + DET_ST + DIV_ST + OUT_ST;

  // cof[k] = a[PA_I]*a[PA_J] - a[PB_I]*a[PB_J]
  localparam logic [IDX_W-1:0] PA_I [NLANE] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
  localparam logic [IDX_W-1:0] PA_J [NLANE] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
  localparam logic [IDX_W-1:0] PB_I [NLANE] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
  localparam logic [IDX_W-1:0] PB_J [NLANE] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

  typedef struct packed {
    logic                         size_two;
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] r00;
    logic signed [DATA_WIDTH-1:0] r01;
    logic signed [DATA_WIDTH-1:0] r02;
    logic signed [DATA_WIDTH-1:0] r10;
    logic signed [DATA_WIDTH-1:0] r11;
    logic signed [DATA_WIDTH-1:0] r12;
    logic signed [DATA_WIDTH-1:0] r20;
    logic signed [DATA_WIDTH-1:0] r21;
    logic signed [DATA_WIDTH-1:0] r22;
    logic                         singular;
    logic                         overflow;
  } inv_t;

  // Per-lane sign and range status that travels with the quotients.
  typedef struct packed {
    logic [NLANE-1:0] neg;
    logic [NLANE-1:0] ovf;
    logic             dzero;
  } quo_ctl_t;

endpackage

// ===== sv/small_matrix_inverse.sv =====
// Top level of the 2x2/3x3 fixed-point matrix inverse pipeline.
// Inverts one 2x2 or 3x3 signed Q16.16 matrix per beat and returns one result beat
// per input beat, in order. The pipeline takes a new matrix every cycle while no
// result beat waits on inv_ready. Its 42 register stages cover, in order, the cofactor
// products and differences, the determinant (split 32x33 products, terms, three-way
// sum, magnitudes), the divider (range check, 33 restoring quotient steps of one
// wide subtract each, rounding) and the output saturation.
// The whole pipeline advances together: when a result beat waits on inv_ready,
// mat_ready drops in the same cycle and every stage holds. Each entry is the exact
// adjugate entry over the determinant, rounded to nearest with ties away from zero,
// then clamped to the 32-bit range with overflow set. A zero determinant gives all
// zero entries with singular set; in 2x2 mode the third row and column read zero.
module small_matrix_inverse (
  input  logic          clk,
  input  logic          rst,
  input  logic          mat_valid,
  output logic          mat_ready,
  input  smi_pkg::mat_t mat,
  output logic          inv_valid,
  input  logic          inv_ready,
  output smi_pkg::inv_t inv
);
  localparam int DW = smi_pkg::DATA_WIDTH;
  localparam int CW = smi_pkg::COF_W;
  localparam int MW = smi_pkg::CMAG_W;
  localparam int GW = smi_pkg::DMAG_W;
  localparam int QW = smi_pkg::MAG_W;
  localparam int NL = smi_pkg::NLANE;
  localparam int NS = smi_pkg::NSTAGE;

  logic                 en;
  logic [NS-1:0]        vld;

  logic signed [CW-1:0] cof  [NL];
  logic signed [DW-1:0] arow [3];
  logic [MW-1:0]        cmag [NL];
  logic [GW-1:0]        dmag;
  logic [NL-1:0]        neg;
  logic                 dzero;
  logic [QW-1:0]        mag  [NL];
  smi_pkg::quo_ctl_t    ctl;

  logic signed [DW-1:0] r_next [NL];
  logic [NL-1:0]        sat;
  smi_pkg::inv_t        inv_next;

  // Advance every stage whenever the output register is empty or being drained.
  // Hold off input beats while in reset.
  assign en        = !vld[NS-1] || inv_ready;
  assign mat_ready = en && !rst;
  assign inv_valid = vld[NS-1];

  // Valid bits march alongside the data; hold them on a stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], mat_valid};
    end
  end

  smi_cof u_cof (
    .clk  (clk),
    .en   (en),
    .mat  (mat),
    .cof  (cof),
    .arow (arow)
  );

  smi_det u_det (
    .clk   (clk),
    .en    (en),
    .cof   (cof),
    .arow  (arow),
    .cmag  (cmag),
    .dmag  (dmag),
    .neg   (neg),
    .dzero (dzero)
  );

  smi_div u_div (
    .clk   (clk),
    .en    (en),
    .cmag  (cmag),
    .dmag  (dmag),
    .neg   (neg),
    .dzero (dzero),
    .mag   (mag),
    .ctl   (ctl)
  );

  // Clamp each rounded magnitude: negative results may reach one step further.
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      sat[l] = ctl.ovf[l] ||
               (mag[l] > ((QW'(1) << (DW-1)) - QW'(!ctl.neg[l])));
      if (ctl.dzero) begin
        r_next[l] = '0;
        sat[l]    = 1'b0;
      end else if (sat[l]) begin
        r_next[l] = ctl.neg[l] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
        r_next[l] = ctl.neg[l] ? DW'(~mag[l] + QW'(1)) : DW'(mag[l]);
      end
    end
    inv_next.r00      = r_next[0];
    inv_next.r01      = r_next[1];
    inv_next.r02      = r_next[2];
    inv_next.r10      = r_next[3];
    inv_next.r11      = r_next[4];
    inv_next.r12      = r_next[5];
    inv_next.r20      = r_next[6];
    inv_next.r21      = r_next[7];
    inv_next.r22      = r_next[8];
    inv_next.singular = ctl.dzero;
    inv_next.overflow = |sat;
  end

  // Output register: hold while the consumer stalls.
  always_ff @(posedge clk) begin
    if (en) begin
      inv <= inv_next;
    end
  end

`ifndef SYNTH
  a_stall_holds_valids: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved during a stall");

  a_last_stage_lands: assert property (@(posedge clk) disable iff (rst)
    (en && vld[NS-2]) |=> inv_valid)
    else $error("item in the last stage did not reach the output");

  a_singular_clean: assert property (@(posedge clk) disable iff (rst)
    (inv_valid && inv.singular) |-> (!inv.overflow && inv.r00 == '0 &&
      inv.r11 == '0 && inv.r22 == '0 && inv.r01 == '0 && inv.r10 == '0))
    else $error("singular result carries nonzero entries or overflow");
`endif

endmodule

// ===== sv/smi_cof.sv =====
// Cofactor stages: entry products, then cofactor differences with 2x2 select.
module smi_cof (
  input  logic                                   clk,
  input  logic                                   en,
  input  smi_pkg::mat_t                          mat,
  output logic signed [smi_pkg::COF_W-1:0]       cof  [smi_pkg::NLANE],
  output logic signed [smi_pkg::DATA_WIDTH-1:0]  arow [3]
);
  localparam int DW = smi_pkg::DATA_WIDTH;
  localparam int PW = smi_pkg::PROD_W;
  localparam int CW = smi_pkg::COF_W;
  localparam int NL = smi_pkg::NLANE;

  logic signed [DW-1:0] a    [NL];
  logic signed [PW-1:0] pa   [NL];
  logic signed [PW-1:0] pb   [NL];
  logic signed [DW-1:0] a_s0 [5];
  logic                 two_s0;

  assign a[0] = mat.m00;
  assign a[1] = mat.m01;
  assign a[2] = mat.m02;
  assign a[3] = mat.m10;
  assign a[4] = mat.m11;
  assign a[5] = mat.m12;
  assign a[6] = mat.m20;
  assign a[7] = mat.m21;
  assign a[8] = mat.m22;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NL; k++) begin
        pa[k] <= PW'(a[smi_pkg::PA_I[k]]) * PW'(a[smi_pkg::PA_J[k]]);
        pb[k] <= PW'(a[smi_pkg::PB_I[k]]) * PW'(a[smi_pkg::PB_J[k]]);
      end
      for (int k = 0; k < 5; k++) begin
        a_s0[k] <= a[k];
      end
      two_s0 <= mat.size_two;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (two_s0) begin
        for (int k = 0; k < NL; k++) begin
          case (k)
            0: cof[k] <= CW'(a_s0[4]);
            1: cof[k] <= -CW'(a_s0[1]);
            3: cof[k] <= -CW'(a_s0[3]);
            4: cof[k] <= CW'(a_s0[0]);
            default: cof[k] <= '0;
          endcase
        end
      end else begin
        for (int k = 0; k < NL; k++) begin
          cof[k] <= CW'(pa[k]) - CW'(pb[k]);
        end
      end
      for (int k = 0; k < 3; k++) begin
        arow[k] <= a_s0[k];
      end
    end
  end

endmodule

// ===== sv/smi_det.sv =====
// Determinant stages: split products, terms, sum, then magnitudes and signs.
module smi_det (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [smi_pkg::COF_W-1:0]       cof  [smi_pkg::NLANE],
  input  logic signed [smi_pkg::DATA_WIDTH-1:0]  arow [3],
  output logic        [smi_pkg::CMAG_W-1:0]      cmag [smi_pkg::NLANE],
  output logic        [smi_pkg::DMAG_W-1:0]      dmag,
  output logic        [smi_pkg::NLANE-1:0]       neg,
  output logic                                   dzero
);
  localparam int DW = smi_pkg::DATA_WIDTH;
  localparam int CW = smi_pkg::COF_W;
  localparam int MW = smi_pkg::CMAG_W;
  localparam int TW = smi_pkg::TERM_W;
  localparam int EW = smi_pkg::DET_W;
  localparam int GW = smi_pkg::DMAG_W;
  localparam int NL = smi_pkg::NLANE;

  logic signed [CW-1:0] cof_s2 [NL];
  logic signed [CW-1:0] cof_s3 [NL];
  logic signed [CW-1:0] cof_s4 [NL];
  logic signed [CW-1:0] pl     [3];
  logic signed [CW-1:0] ph     [3];
  logic signed [TW-1:0] term   [3];
  logic signed [EW-1:0] det;
  logic signed [EW-1:0] det_neg;
  logic signed [CW-1:0] cof_neg [NL];

  // Expansion along row 0 uses cofactors 0, 3 and 6.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 3; t++) begin
        pl[t] <= CW'(arow[t]) * CW'($signed({1'b0, cof[3*t][DW-1:0]}));
        ph[t] <= CW'(arow[t]) * CW'($signed(cof[3*t][CW-1:DW]));
      end
      cof_s2 <= cof;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 3; t++) begin
        term[t] <= (TW'(ph[t]) <<< DW) + TW'(pl[t]);
      end
      cof_s3 <= cof_s2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det    <= EW'(term[0]) + EW'(term[1]) + EW'(term[2]);
      cof_s4 <= cof_s3;
    end
  end

  always_comb begin
    det_neg = -det;
    for (int k = 0; k < NL; k++) begin
      cof_neg[k] = -cof_s4[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dmag  <= det[EW-1] ? det_neg[GW-1:0] : det[GW-1:0];
      dzero <= (det == '0);
      for (int k = 0; k < NL; k++) begin
        cmag[k] <= cof_s4[k][CW-1] ? cof_neg[k][MW-1:0] : cof_s4[k][MW-1:0];
        neg[k]  <= cof_s4[k][CW-1] ^ det[EW-1];
      end
    end
  end

endmodule

// ===== sv/smi_div.sv =====
// Pipelined restoring divider: range check, one quotient bit per stage, rounding.
module smi_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [smi_pkg::CMAG_W-1:0]        cmag [smi_pkg::NLANE],
  input  logic [smi_pkg::DMAG_W-1:0]        dmag,
  input  logic [smi_pkg::NLANE-1:0]         neg,
  input  logic                              dzero,
  output logic [smi_pkg::MAG_W-1:0]         mag  [smi_pkg::NLANE],
  output smi_pkg::quo_ctl_t                 ctl
);
  localparam int GW = smi_pkg::DMAG_W;
  localparam int QB = smi_pkg::QBITS;
  localparam int NL = smi_pkg::NLANE;

  logic [GW-1:0]    rem  [QB+1][NL];
  logic [QB-1:0]    quo  [QB+1][NL];
  logic [GW+1:0]    trial [QB+1][NL];
  logic [GW-1:0]    dd   [QB+1];
  smi_pkg::quo_ctl_t cs  [QB+1];

  // Quotient of |C| * 2^(QBITS) / |D| stays below 2^QBITS exactly when |C| < |D|.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        rem[0][l]    <= GW'(cmag[l]);
        quo[0][l]    <= '0;
        cs[0].ovf[l] <= (GW'(cmag[l]) >= dmag);
      end
      dd[0]       <= dmag;
      cs[0].neg   <= neg;
      cs[0].dzero <= dzero;
    end
  end

  assign trial[0] = '{default: '0};

  for (genvar s = 1; s <= QB; s++) begin : g_step
    for (genvar l = 0; l < NL; l++) begin : g_lane
      assign trial[s][l] = {1'b0, rem[s-1][l], 1'b0} - {2'b00, dd[s-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s][l] <= trial[s][l][GW+1] ? {rem[s-1][l][GW-2:0], 1'b0} : trial[s][l][GW-1:0];
          quo[s][l] <= {quo[s-1][l][QB-2:0], ~trial[s][l][GW+1]};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dd[s] <= dd[s-1];
        cs[s] <= cs[s-1];
      end
    end
  end

  // Round half away from zero: the last quotient bit is the half bit.
  logic [QB:0] rnd [NL];
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      rnd[l] = {1'b0, quo[QB][l]} + (QB+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        mag[l] <= rnd[l][QB:1];
      end
      ctl <= cs[QB];
    end
  end

endmodule
